// ===== hw/rtl/spd_pkg.sv =====
// Types and constants shared by the SPH poly6 density accumulator modules.
`timescale 1ns / 1ps
`default_nettype none
package spd_pkg;

   localparam int ACC_W     = 48;
   localparam int PRESS_W   = 49;
   localparam int MASS_W    = 16;
   localparam int KSCALE_W  = 16;
   localparam int RAD_W     = 32;
   localparam int T_W       = 16;
   localparam int MK_W      = 32;
   localparam int C3_W      = 48;
   localparam int PROD_W    = 56;
   localparam int FRAC_W    = 25;
   localparam int MUL_W     = 32;
   localparam int CSR_W     = 48;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_RADIUS_SQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SCALE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REST_DENSITY     = 2'd2;

   localparam logic [RAD_W-1:0] RAD_RESET = 32'd16777216;
   localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_Z,
      OP_T,
      OP_T_SQ,
      OP_T_CUBE,
      OP_MASS,
      OP_HIGH,
      OP_LOW,
      OP_ACC,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_RANGE,
      ST_T_SQ,
      ST_T_CUBE,
      ST_MASS,
      ST_HIGH,
      ST_LOW,
      ST_ACC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic present;
      logic last;
      logic in_range;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/spd_if.sv =====
// Handshake channel interfaces for neighbour beats and density result beats.
`timescale 1ns / 1ps
`default_nettype none
interface spd_req_if #(
   parameter int OFFSET_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [OFFSET_BITS-1:0] offset_x;
   logic signed [OFFSET_BITS-1:0] offset_y;
   logic signed [OFFSET_BITS-1:0] offset_z;
   logic [15:0]                   neighbour_mass;
   logic                          present;
   logic                          last;

   modport source (output valid, offset_x, offset_y, offset_z, neighbour_mass, present, last,
                   input ready);
   modport sink (input valid, offset_x, offset_y, offset_z, neighbour_mass, present, last,
                 output ready);
endinterface

interface spd_rsp_if;
   logic               valid;
   logic               ready;
   logic [47:0]        density;
   logic signed [48:0] pressure;
   logic               saturated;

   modport source (output valid, density, pressure, saturated, input ready);
   modport sink (input valid, density, pressure, saturated, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/spd_ctrl.sv =====
// Sequencer that steps the shared multiplier datapath through one neighbour beat.
`timescale 1ns / 1ps
`default_nettype none
module spd_ctrl
   import spd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd.op    = OP_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            if (status.present) begin
               cmd.op   = OP_SQ_X;
               state_in = ST_SQ_Y;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SQ_Y: begin
            cmd.op   = OP_SQ_Y;
            state_in = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            cmd.op   = OP_SQ_Z;
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (status.in_range) begin
               cmd.op   = OP_T;
               state_in = ST_T_SQ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_T_SQ: begin
            cmd.op   = OP_T_SQ;
            state_in = ST_T_CUBE;
         end
         ST_T_CUBE: begin
            cmd.op   = OP_T_CUBE;
            state_in = ST_MASS;
         end
         ST_MASS: begin
            cmd.op   = OP_MASS;
            state_in = ST_HIGH;
         end
         ST_HIGH: begin
            cmd.op   = OP_HIGH;
            state_in = ST_LOW;
         end
         ST_LOW: begin
            cmd.op   = OP_LOW;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.op   = OP_ACC;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/spd_datapath.sv =====
// Datapath with one shared multiplier, accumulator, settings and result register.
`timescale 1ns / 1ps
`default_nettype none
module spd_datapath
   import spd_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   output status_type                         status,
   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_W-1:0]              csr_wdata,
   input  wire logic signed [OFFSET_BITS-1:0] offset_x,
   input  wire logic signed [OFFSET_BITS-1:0] offset_y,
   input  wire logic signed [OFFSET_BITS-1:0] offset_z,
   input  wire logic [MASS_W-1:0]             neighbour_mass,
   input  wire logic                          present,
   input  wire logic                          last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [ACC_W-1:0]                   density,
   output logic signed [PRESS_W-1:0]          pressure,
   output logic                               saturated
);

   localparam int R2_W  = 2 * OFFSET_BITS;
   localparam int CMP_W = (R2_W > RAD_W) ? R2_W : RAD_W;

   function automatic logic [OFFSET_BITS-1:0] mag_of(input logic [OFFSET_BITS-1:0] v);
      return v[OFFSET_BITS-1] ? (~v + 1'b1) : v;
   endfunction

   logic [RAD_W-1:0]       rad_ff, rad_in;
   logic [KSCALE_W-1:0]    kscale_ff, kscale_in;
   logic [ACC_W-1:0]       rest_ff, rest_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]       density_ff, density_in;
   logic [PRESS_W-1:0]     pressure_ff, pressure_in;
   logic                   saturated_ff, saturated_in;
   logic [OFFSET_BITS-1:0] ax_ff, ax_in;
   logic [OFFSET_BITS-1:0] ay_ff, ay_in;
   logic [OFFSET_BITS-1:0] az_ff, az_in;
   logic [MASS_W-1:0]      mass_ff, mass_in;
   logic                   present_ff, present_in;
   logic                   last_ff, last_in;
   logic [R2_W-1:0]        r2_ff, r2_in;
   logic [T_W-1:0]         t_ff, t_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [C3_W-1:0]        c3_ff, c3_in;
   logic [MK_W-1:0]        mk_ff, mk_in;
   logic [FRAC_W-1:0]      frac_ff, frac_in;

   logic [MUL_W-1:0]       mul_a;
   logic [MUL_W-1:0]       mul_b;
   logic [2*MUL_W-1:0]     mul_p;
   logic [CMP_W-1:0]       rad_ext;
   logic [CMP_W-1:0]       r2_ext;
   logic [CMP_W-1:0]       diff;
   logic [PROD_W:0]        lo_sum;
   logic [ACC_W+1:0]       acc_sum;

   assign rad_ext = CMP_W'(rad_ff);
   assign r2_ext  = CMP_W'(r2_ff);
   assign diff    = rad_ext - r2_ext;
   assign mul_p   = mul_a * mul_b;
   assign lo_sum  = (PROD_W + 1)'({prod_ff[7:0], 24'd0}) + (PROD_W + 1)'(mul_p[PROD_W-1:0]);
   assign acc_sum = (ACC_W + 2)'(acc_ff) + (ACC_W + 2)'(prod_ff[PROD_W-1:8])
                  + (ACC_W + 2)'(frac_ff);

   assign status.present  = present_ff;
   assign status.last     = last_ff;
   assign status.in_range = (r2_ext <= rad_ext);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign density   = density_ff;
   assign pressure  = pressure_ff;
   assign saturated = saturated_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_SQ_X: begin
            mul_a = MUL_W'(ax_ff);
            mul_b = MUL_W'(ax_ff);
         end
         OP_SQ_Y: begin
            mul_a = MUL_W'(ay_ff);
            mul_b = MUL_W'(ay_ff);
         end
         OP_SQ_Z: begin
            mul_a = MUL_W'(az_ff);
            mul_b = MUL_W'(az_ff);
         end
         OP_T_SQ: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(t_ff);
         end
         OP_T_CUBE: begin
            mul_a = prod_ff[MUL_W-1:0];
            mul_b = MUL_W'(t_ff);
         end
         OP_MASS: begin
            mul_a = MUL_W'(mass_ff);
            mul_b = MUL_W'(kscale_ff);
         end
         OP_HIGH: begin
            mul_a = MUL_W'(c3_ff[C3_W-1:24]);
            mul_b = mk_ff;
         end
         OP_LOW: begin
            mul_a = MUL_W'(c3_ff[23:0]);
            mul_b = mk_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      rad_in       = rad_ff;
      kscale_in    = kscale_ff;
      rest_in      = rest_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      density_in   = density_ff;
      pressure_in  = pressure_ff;
      saturated_in = saturated_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      mass_in      = mass_ff;
      present_in   = present_ff;
      last_in      = last_ff;
      r2_in        = r2_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      c3_in        = c3_ff;
      mk_in        = mk_ff;
      frac_in      = frac_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SMOOTH_RADIUS_SQ: rad_in    = csr_wdata[RAD_W-1:0];
            CSR_KERNEL_SCALE:     kscale_in = csr_wdata[KSCALE_W-1:0];
            CSR_REST_DENSITY:     rest_in   = csr_wdata[ACC_W-1:0];
            default:              rad_in    = rad_ff;
         endcase
      end

      unique case (cmd.op)
         OP_LOAD: begin
            ax_in      = mag_of(offset_x);
            ay_in      = mag_of(offset_y);
            az_in      = mag_of(offset_z);
            mass_in    = neighbour_mass;
            present_in = present;
            last_in    = last;
         end
         OP_SQ_X: r2_in = mul_p[R2_W-1:0];
         OP_SQ_Y: r2_in = r2_ff + mul_p[R2_W-1:0];
         OP_SQ_Z: r2_in = r2_ff + mul_p[R2_W-1:0];
         OP_T: t_in = diff[RAD_W-1:16];
         OP_T_SQ: prod_in = mul_p[PROD_W-1:0];
         OP_T_CUBE: c3_in = mul_p[C3_W-1:0];
         OP_MASS: mk_in = mul_p[MK_W-1:0];
         OP_HIGH: prod_in = mul_p[PROD_W-1:0];
         OP_LOW: frac_in = lo_sum[PROD_W:32];
         OP_ACC: begin
            if (acc_sum > (ACC_W + 2)'(ACC_MAX)) begin
               acc_in = ACC_MAX;
               ovf_in = 1'b1;
            end else begin
               acc_in = acc_sum[ACC_W-1:0];
            end
         end
         OP_EMIT: begin
            density_in   = acc_ff;
            pressure_in  = {1'b0, acc_ff} - {1'b0, rest_ff};
            saturated_in = ovf_ff;
            rsp_valid_in = 1'b1;
            acc_in       = '0;
            ovf_in       = 1'b0;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff       <= RAD_RESET;
         kscale_ff    <= '0;
         rest_ff      <= '0;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rad_ff       <= rad_in;
         kscale_ff    <= kscale_in;
         rest_ff      <= rest_in;
         acc_ff       <= acc_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      density_ff   <= density_in;
      pressure_ff  <= pressure_in;
      saturated_ff <= saturated_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      az_ff        <= az_in;
      mass_ff      <= mass_in;
      present_ff   <= present_in;
      last_ff      <= last_in;
      r2_ff        <= r2_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      c3_ff        <= c3_in;
      mk_ff        <= mk_in;
      frac_ff      <= frac_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sph_poly6_density_accumulator_core.sv =====
// A beat is taken only in idle and then steps through the x, y and z squares, range check,
// t squared, t cubed, mass, high and low products, accumulate and finish; a beat outside the
// radius goes to finish from the range check, an empty one from the x square. One shared
// 32x32 multiplier serves eight products; a closing result is held in an output register.
// Reset (synchronous): clears the accumulator, the overflow flag and the result valid,
// and sets smooth_radius_sq to 2^24, kernel_scale and rest_density to zero.
`timescale 1ns / 1ps
`default_nettype none
module sph_poly6_density_accumulator_core
   import spd_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   spd_req_if.sink                   req_if,
   spd_rsp_if.source                 rsp_if,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   spd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   spd_datapath #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .offset_x       (req_if.offset_x),
      .offset_y       (req_if.offset_y),
      .offset_z       (req_if.offset_z),
      .neighbour_mass (req_if.neighbour_mass),
      .present        (req_if.present),
      .last           (req_if.last),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .density        (rsp_if.density),
      .pressure       (rsp_if.pressure),
      .saturated      (rsp_if.saturated)
   );

endmodule
`default_nettype wire

// ===== tb/sph_poly6_density_accumulator_core_test.sv =====
// Self-checking testbench for the SPH poly6 density accumulator core.
`timescale 1ns / 1ps
module sph_poly6_density_accumulator_core_test
   import spd_pkg::*;
;

   localparam int OFF_W       = 16;
   localparam int RESET_LEN   = 10;
   localparam int DRAIN_LEN   = 16;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 75;
   localparam int GAP_PHASE_A = 2;
   localparam int GAP_PHASE_B = 4;
   localparam int HOLD_PHASE  = 1;
   localparam int PAUSE_PHASE = 3;
   localparam int PAUSE_AT    = 40;

   localparam logic signed [PRESS_W-1:0] NEG_ACC_MAX = -$signed({1'b0, ACC_MAX});

   typedef struct packed {
      logic signed [OFF_W-1:0] offset_x;
      logic signed [OFF_W-1:0] offset_y;
      logic signed [OFF_W-1:0] offset_z;
      logic [MASS_W-1:0]       neighbour_mass;
      logic                    present;
      logic                    last;
   } neighbour_type;

   typedef struct packed {
      logic [ACC_W-1:0]          density;
      logic signed [PRESS_W-1:0] pressure;
      logic                      saturated;
   } density_type;

   typedef enum {ROW_CONFIG, ROW_PREDICTED, ROW_TYPED} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [RAD_W-1:0]    radius_sq;
      logic [KSCALE_W-1:0] kscale;
      logic [ACC_W-1:0]    rest;
      neighbour_type       nb;
      density_type         want;
   } row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   spd_req_if #(.OFFSET_BITS(OFF_W)) req_ch ();
   spd_rsp_if rsp_ch ();

   sph_poly6_density_accumulator_core #(.OFFSET_BITS(OFF_W)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [RAD_W-1:0]    cfg_radius_sq;
   logic [KSCALE_W-1:0] cfg_kscale;
   logic [ACC_W-1:0]    cfg_rest;
   logic [ACC_W-1:0]    acc_sum;
   logic                acc_clipped;

   density_type density_q[$];
   row_type     plan[$];

   logic        beat_typed;
   density_type beat_want;

   bit no_gaps;
   bit long_hold_req;
   int errors;
   int stall_cycles;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [OFF_W-1:0] magnitude(input logic signed [OFF_W-1:0] v);
      return v[OFF_W-1] ? (~v + 1'b1) : v;
   endfunction

   // Update the running sum with one neighbour; return 1 with the closing result on last.
   function automatic bit predict_density(input neighbour_type nb, output density_type res);
      logic [OFF_W-1:0] ax, ay, az;
      logic [33:0]      r2;
      logic [RAD_W-1:0] diff;
      logic [T_W-1:0]   t;
      logic [C3_W-1:0]  cube;
      logic [MK_W-1:0]  mk;
      logic [79:0]      prod;
      logic [ACC_W:0]   total;
      ax = magnitude(nb.offset_x);
      ay = magnitude(nb.offset_y);
      az = magnitude(nb.offset_z);
      r2 = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay) + 34'(az) * 34'(az);
      res = '0;
      if (nb.present && r2 <= 34'(cfg_radius_sq)) begin
         diff = cfg_radius_sq - r2[RAD_W-1:0];
         t = diff[RAD_W-1:16];
         cube = 48'(t) * 48'(t) * 48'(t);
         mk = 32'(nb.neighbour_mass) * 32'(cfg_kscale);
         prod = 80'(cube) * 80'(mk);
         total = 49'(acc_sum) + 49'(prod[79:32]);
         if (total > 49'(ACC_MAX)) begin
            acc_sum = ACC_MAX;
            acc_clipped = 1'b1;
         end else begin
            acc_sum = total[ACC_W-1:0];
         end
      end
      if (!nb.last)
         return 1'b0;
      res.density = acc_sum;
      res.pressure = $signed({1'b0, acc_sum}) - $signed({1'b0, cfg_rest});
      res.saturated = acc_clipped;
      acc_sum = '0;
      acc_clipped = 1'b0;
      return 1'b1;
   endfunction

   // Track register writes, predict on each input beat, check each result beat.
   always @(posedge clock) begin
      density_type want;
      density_type got;
      bit          closes;
      if (reset) begin
         cfg_radius_sq = RAD_RESET;
         cfg_kscale = '0;
         cfg_rest = '0;
         acc_sum = '0;
         acc_clipped = 1'b0;
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (csr_we) begin
            case (csr_index)
               CSR_SMOOTH_RADIUS_SQ: cfg_radius_sq = csr_wdata[RAD_W-1:0];
               CSR_KERNEL_SCALE:     cfg_kscale = csr_wdata[KSCALE_W-1:0];
               CSR_REST_DENSITY:     cfg_rest = csr_wdata[ACC_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            stall_cycles = 0;
            closes = predict_density({req_ch.offset_x, req_ch.offset_y, req_ch.offset_z,
                                      req_ch.neighbour_mass, req_ch.present, req_ch.last},
                                     want);
            if (closes)
               density_q.insert(density_q.size(), beat_typed ? beat_want : want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            stall_cycles = 0;
            got = '{rsp_ch.density, rsp_ch.pressure, rsp_ch.saturated};
            if (density_q.size() == 0) begin
               $error("unexpected result beat: density %h pressure %h saturated %b",
                      got.density, got.pressure, got.saturated);
               errors++;
            end else begin
               want = density_q.pop_front();
               if (got.density !== want.density) begin
                  $error("density: expected %h, got %h", want.density, got.density);
                  errors++;
               end
               if (got.pressure !== want.pressure) begin
                  $error("pressure: expected %h, got %h", want.pressure, got.pressure);
                  errors++;
               end
               if (got.saturated !== want.saturated) begin
                  $error("saturated: expected %b, got %b", want.saturated, got.saturated);
                  errors++;
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Result side: stall a random number of cycles per beat, or hold off for a long stretch.
   initial begin
      int wait_len;
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         if (long_hold_req) begin
            wait_len = LONG_HOLD;
            long_hold_req = 1'b0;
         end else begin
            wait_len = no_gaps ? 0 : $urandom_range(0, 11);
         end
         if (wait_len != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_len) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
      end
   end

   function automatic row_type cfg_row(input logic [RAD_W-1:0] radius_sq,
                                       input logic [KSCALE_W-1:0] kscale,
                                       input logic [ACC_W-1:0] rest);
      row_type r;
      r = '{kind: ROW_CONFIG, radius_sq: radius_sq, kscale: kscale, rest: rest,
            nb: '0, want: '0};
      return r;
   endfunction

   function automatic row_type beat_row(input logic signed [OFF_W-1:0] x, y, z,
                                        input logic [MASS_W-1:0] mass,
                                        input logic present, last,
                                        input row_kind_type kind,
                                        input logic [ACC_W-1:0] density,
                                        input logic signed [PRESS_W-1:0] pressure,
                                        input logic saturated);
      row_type r;
      r = '{kind: kind, radius_sq: '0, kscale: '0, rest: '0,
            nb: '{x, y, z, mass, present, last}, want: '{density, pressure, saturated}};
      return r;
   endfunction

   function automatic void add_row(input row_type r);
      plan.insert(plan.size(), r);
   endfunction

   function automatic logic signed [OFF_W-1:0] rand_offset(input int limit);
      int mag;
      mag = $urandom_range(0, limit);
      return ($urandom_range(0, 1) != 0) ? OFF_W'(-mag) : OFF_W'(mag);
   endfunction

   function automatic logic [ACC_W-1:0] rand48();
      return ACC_W'({$urandom(), $urandom()});
   endfunction

   task automatic send_neighbour(input neighbour_type nb, input bit typed,
                                 input density_type want);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.offset_x <= nb.offset_x;
      req_ch.offset_y <= nb.offset_y;
      req_ch.offset_z <= nb.offset_z;
      req_ch.neighbour_mass <= nb.neighbour_mass;
      req_ch.present <= nb.present;
      req_ch.last <= nb.last;
      beat_typed <= typed;
      beat_want <= want;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Drop valid, wait for every pending result, then let in-flight beats finish.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (density_q.size() != 0);
      repeat (DRAIN_LEN) @(posedge clock);
   endtask

   task automatic load_regs(input logic [RAD_W-1:0] radius_sq,
                            input logic [KSCALE_W-1:0] kscale,
                            input logic [ACC_W-1:0] rest);
      logic [31:0] junk;
      junk = $urandom();
      csr_we <= 1'b1;
      csr_index <= CSR_SMOOTH_RADIUS_SQ;
      csr_wdata <= {junk[15:0], radius_sq};
      @(posedge clock);
      csr_index <= CSR_KERNEL_SCALE;
      csr_wdata <= {junk, kscale};
      @(posedge clock);
      csr_index <= CSR_REST_DENSITY;
      csr_wdata <= rest;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      neighbour_type nb;
      density_type   dummy;
      row_type       r;
      int            sent;
      int            len;
      int            limit;
      bit            open_list;
      logic [RAD_W-1:0]    radius_sq;
      logic [KSCALE_W-1:0] kscale;
      logic [ACC_W-1:0]    rest;

      errors = 0;
      no_gaps = 1'b0;
      long_hold_req = 1'b0;
      dummy = '0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_SMOOTH_RADIUS_SQ;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.offset_x <= '0;
      req_ch.offset_y <= '0;
      req_ch.offset_z <= '0;
      req_ch.neighbour_mass <= '0;
      req_ch.present <= 1'b0;
      req_ch.last <= 1'b0;
      beat_typed <= 1'b0;
      beat_want <= '0;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      // reset registers: zero kernel scale gives zero density
      add_row(beat_row(0, 0, 0, 16'hFFFF, 1, 1, ROW_TYPED, 0, 0, 0));
      add_row(beat_row(16'sh7FFF, 16'sh8000, 1, 16'hFFFF, 0, 1, ROW_TYPED, 0, 0, 0));
      // widest radius, full scale: two centered neighbours clip
      add_row(cfg_row(32'hFFFF_FFFF, 16'hFFFF, 0));
      add_row(beat_row(0, 0, 0, 16'hFFFF, 1, 0, ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(0, 0, 0, 16'hFFFF, 1, 1, ROW_TYPED, ACC_MAX, ACC_MAX, 1));
      add_row(beat_row(0, 0, 0, 0, 0, 1, ROW_TYPED, 0, 0, 0));
      add_row(beat_row(16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 1, 0,
                       ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(16'sh7FFF, -16'sd1, 1, 0, 1, 0, ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(1, -16'sd1, 16'sh7FFF, 16'h8000, 1, 1, ROW_PREDICTED, 0, 0, 0));
      // unit radius: boundary, just outside, empty items; full rest density
      add_row(cfg_row(RAD_RESET, 16'hFFFF, ACC_MAX));
      add_row(beat_row(16'sd4096, 0, 0, 16'hFFFF, 1, 0, ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(16'sd4097, 0, 0, 16'hFFFF, 1, 1, ROW_TYPED, 0, NEG_ACC_MAX, 0));
      add_row(beat_row(0, 0, 0, 16'hFFFF, 1, 1, ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(-16'sd4096, 1, 0, 16'hFFFF, 1, 0, ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(0, 0, 0, 16'hFFFF, 0, 0, ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(0, 0, 0, 16'hFFFF, 0, 1, ROW_TYPED, 0, NEG_ACC_MAX, 0));
      // clipped sum equal to rest density
      add_row(cfg_row(32'hFFFF_FFFF, 16'hFFFF, ACC_MAX));
      add_row(beat_row(0, 0, 0, 16'hFFFF, 1, 0, ROW_PREDICTED, 0, 0, 0));
      add_row(beat_row(0, 0, 0, 16'hFFFF, 1, 1, ROW_TYPED, ACC_MAX, 0, 1));
      // zero radius: only the center counts, with a zero term
      add_row(cfg_row(0, 1, 1));
      add_row(beat_row(0, 0, 0, 1, 1, 1, ROW_TYPED, 0, -49'sd1, 0));
      add_row(beat_row(0, 0, 1, 16'hFFFF, 1, 1, ROW_TYPED, 0, -49'sd1, 0));
      // list left open into the random part
      add_row(beat_row(16'sd1234, -16'sd2345, 16'sd3456, 16'hABCD, 1, 0,
                       ROW_PREDICTED, 0, 0, 0));

      foreach (plan[i]) begin
         r = plan[i];
         if (r.kind == ROW_CONFIG) begin
            settle();
            load_regs(r.radius_sq, r.kscale, r.rest);
         end else begin
            send_neighbour(r.nb, r.kind == ROW_TYPED, r.want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               radius_sq = 32'hFFFF_FFFF;
               kscale = 16'hFFFF;
               rest = rand48();
            end
            1: begin
               radius_sq = RAD_RESET;
               kscale = KSCALE_W'($urandom());
               rest = '0;
            end
            2: begin
               radius_sq = RAD_W'($urandom_range(0, 65536));
               kscale = KSCALE_W'($urandom());
               rest = rand48();
            end
            3: begin
               radius_sq = $urandom();
               kscale = KSCALE_W'($urandom());
               rest = ACC_MAX;
            end
            4: begin
               radius_sq = $urandom();
               kscale = KSCALE_W'($urandom());
               rest = rand48();
            end
            default: begin
               radius_sq = 32'd1 << $urandom_range(16, 31);
               kscale = 16'hFFFF;
               rest = rand48();
            end
         endcase
         settle();
         load_regs(radius_sq, kscale, rest);
         no_gaps = (phase == GAP_PHASE_A) || (phase == GAP_PHASE_B);
         if (phase == HOLD_PHASE)
            long_hold_req = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            len = $urandom_range(1, 8);
            open_list = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 4))
               0: limit = 32768;
               1: limit = 8192;
               2: limit = 2048;
               3: limit = 512;
               default: limit = 64;
            endcase
            for (int k = 0; k < len; k++) begin
               nb.offset_x = rand_offset(limit);
               nb.offset_y = rand_offset(limit);
               nb.offset_z = rand_offset(limit);
               case ($urandom_range(0, 7))
                  0: nb.neighbour_mass = 16'hFFFF;
                  1: nb.neighbour_mass = '0;
                  default: nb.neighbour_mass = MASS_W'($urandom());
               endcase
               nb.present = ($urandom_range(0, 9) != 0);
               nb.last = ((k == len - 1) && !open_list) || ($urandom_range(0, 19) == 0);
               send_neighbour(nb, 1'b0, dummy);
               sent++;
               if (phase == PAUSE_PHASE && sent == PAUSE_AT) begin
                  req_ch.valid <= 1'b0;
                  do @(posedge clock); while (density_q.size() != 0);
               end
            end
         end
      end

      no_gaps = 1'b0;
      settle();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/spd_pkg.sv
hw/rtl/spd_if.sv
hw/rtl/spd_ctrl.sv
hw/rtl/spd_datapath.sv
hw/rtl/sph_poly6_density_accumulator_core.sv
tb/sph_poly6_density_accumulator_core_test.sv
